FILE: rtl/core/srfp_pkg.sv
package srfp_pkg;

  localparam int FrameLength  = 10;
  localparam int PosW         = $clog2(FrameLength);
  localparam int PayloadBytes = FrameLength - 4;
  localparam int SlotW        = $clog2(PayloadBytes);

  typedef logic [PosW-1:0]  pos_t;
  typedef logic [SlotW-1:0] slot_t;

  // Positions within a frame.
  localparam pos_t PosHeadFirst    = PosW'(0);
  localparam pos_t PosHeadSecond   = PosW'(1);
  localparam pos_t PosPayloadFirst = PosW'(2);
  localparam pos_t PosPayloadLast  = PosW'(FrameLength - 3);
  localparam pos_t PosCheck        = PosW'(FrameLength - 2);
  localparam pos_t PosTail         = PosW'(FrameLength - 1);

  localparam logic [7:0] HeadFirst   = 8'hA5;
  localparam logic [7:0] HeadSecond  = 8'h5A;
  localparam logic [7:0] FrameTail   = 8'h0D;
  localparam logic [7:0] EncoderCode = 8'h07;
  localparam logic [7:0] ReplyBit    = 8'h80;
  localparam logic [7:0] EncoderCmd  = EncoderCode | ReplyBit;

  localparam logic ReplyEncoder = 1'b0;
  localparam logic ReplyAck     = 1'b1;

  // Offsets of the fields inside the payload store (frame byte minus two).
  localparam slot_t SlotCommand  = SlotW'(0);
  localparam slot_t SlotSequence = SlotW'(1);
  localparam slot_t SlotLeftLo   = SlotW'(2);
  localparam slot_t SlotLeftHi   = SlotW'(3);
  localparam slot_t SlotRightLo  = SlotW'(4);
  localparam slot_t SlotRightHi  = SlotW'(5);
  localparam slot_t SlotStatus   = SlotW'(2);

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } stage_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] left_mm;
    logic signed [15:0] right_mm;
    logic [7:0]         command;
    logic [7:0]         sequence_nr;
    logic [7:0]         status;
  } reply_t;

endpackage

FILE: rtl/core/serial_reply_frame_parser.sv
// Reply path: a frame's tail byte is held in the byte register, and its reply is then
// registered in the result register; a stalled, full result register holds the byte register.
// Throughput: one byte per cycle; the byte register and the result register keep
// the link moving while a finished reply waits, and only a stalled, full result
// register holds off further bytes.
// Reset: asynchronous, active low; clears the frame position and both valid flags,
// so the parser starts hunting for a head byte.
module serial_reply_frame_parser
  import srfp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               reply_kind_o,
  output logic signed [15:0] left_distance_mm_o,
  output logic signed [15:0] right_distance_mm_o,
  output logic [7:0]         ack_command_o,
  output logic [7:0]         ack_sequence_o,
  output logic [7:0]         ack_status_o
);

  stage_t stage;
  logic   advance;
  logic   produce;
  reply_t reply_next;
  reply_t reply;

  srfp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (advance),
    .stage_o    (stage)
  );

  srfp_frame_track u_frame_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .stage_i   (stage),
    .advance_i (advance),
    .produce_o (produce),
    .reply_o   (reply_next)
  );

  srfp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .produce_i   (produce),
    .reply_i     (reply_next),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .advance_o   (advance),
    .reply_o     (reply)
  );

  assign reply_kind_o        = reply.kind;
  assign left_distance_mm_o  = reply.left_mm;
  assign right_distance_mm_o = reply.right_mm;
  assign ack_command_o       = reply.command;
  assign ack_sequence_o      = reply.sequence_nr;
  assign ack_status_o        = reply.status;

  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while the result side was free");

  a_reply_fields_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && reply_kind_o == ReplyAck) |->
      (left_distance_mm_o == '0 && right_distance_mm_o == '0))
    else $error("acknowledge carries distance data");

endmodule

FILE: rtl/core/srfp_in_stage.sv
module srfp_in_stage
  import srfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  input  logic       advance_i,
  output stage_t     stage_o
);

  logic       valid_q;
  logic [7:0] data_q;
  logic       accept;

  // The held byte only blocks a new request when the parser cannot take it.
  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (accept) begin
      valid_q <= 1'b1;
    end else if (advance_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= rx_byte_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.data  = data_q;

endmodule

FILE: rtl/core/srfp_frame_track.sv
module srfp_frame_track
  import srfp_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  stage_t stage_i,
  input  logic   advance_i,
  output logic   produce_o,
  output reply_t reply_o
);

  pos_t       pos_q, pos_d, pos;
  logic [7:0] xor_q, xor_d;
  logic       sum_ok_q, sum_ok_d;
  logic [7:0] store_q [PayloadBytes];
  logic       take;
  logic       wr_en;
  slot_t      slot;
  logic [7:0] b;

  assign take = stage_i.valid && advance_i;
  assign b    = stage_i.data;

  always_comb begin
    pos       = (pos_q >= PosW'(FrameLength)) ? PosHeadFirst : pos_q;
    pos_d     = pos_q;
    xor_d     = xor_q;
    sum_ok_d  = sum_ok_q;
    wr_en     = 1'b0;
    produce_o = 1'b0;
    if (take) begin
      case (pos) inside
        PosHeadFirst: begin
          pos_d = (b == HeadFirst) ? PosHeadSecond : PosHeadFirst;
          xor_d = b;
        end
        PosHeadSecond: begin
          if (b == HeadSecond) begin
            pos_d = PosPayloadFirst;
            xor_d = xor_q ^ b;
          end else begin
            // A repeated first head byte restarts the frame in place.
            pos_d = (b == HeadFirst) ? PosHeadSecond : PosHeadFirst;
            xor_d = b;
          end
        end
        [PosPayloadFirst:PosPayloadLast]: begin
          pos_d = pos + PosW'(1);
          xor_d = xor_q ^ b;
          wr_en = 1'b1;
        end
        PosCheck: begin
          sum_ok_d = (b == xor_q);
          pos_d    = PosTail;
        end
        PosTail: begin
          pos_d     = PosHeadFirst;
          produce_o = (b == FrameTail) && sum_ok_q;
        end
        default: begin
          pos_d = PosHeadFirst;
        end
      endcase
    end
  end

  assign slot = SlotW'(pos - PosPayloadFirst);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= PosHeadFirst;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xor_q    <= xor_d;
    sum_ok_q <= sum_ok_d;
    if (wr_en) begin
      store_q[slot] <= b;
    end
  end

  always_comb begin
    reply_o = '0;
    if (store_q[SlotCommand] == EncoderCmd) begin
      reply_o.kind     = ReplyEncoder;
      reply_o.left_mm  = {store_q[SlotLeftHi], store_q[SlotLeftLo]};
      reply_o.right_mm = {store_q[SlotRightHi], store_q[SlotRightLo]};
    end else begin
      reply_o.kind        = ReplyAck;
      reply_o.command     = store_q[SlotCommand];
      reply_o.sequence_nr = store_q[SlotSequence];
      reply_o.status      = store_q[SlotStatus];
    end
  end

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < PosW'(FrameLength))
    else $error("frame position left the frame");

  a_produce_at_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    produce_o |-> (pos_q == PosTail) && take)
    else $error("reply produced away from the tail byte");

  a_tail_returns_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && pos_q == PosTail) |=> (pos_q == PosHeadFirst))
    else $error("position did not wrap after the tail byte");

endmodule

FILE: rtl/core/srfp_out_stage.sv
module srfp_out_stage
  import srfp_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   produce_i,
  input  reply_t reply_i,
  input  logic   out_stall_i,
  output logic   out_valid_o,
  output logic   advance_o,
  output reply_t reply_o
);

  logic   valid_q;
  reply_t reply_q;

  // The parser may move on whenever the result register is free or draining.
  assign advance_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (produce_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce_i) begin
      reply_q <= reply_i;
    end
  end

  assign out_valid_o = valid_q;
  assign reply_o     = reply_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    produce_i |-> advance_o)
    else $error("result register overwritten while stalled");

endmodule

FILE: dv/reply_checker.sv
`timescale 1ns / 100ps

module reply_checker
  import srfp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [7:0]         rx_byte_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               reply_kind_i,
  input  logic signed [15:0] left_distance_mm_i,
  input  logic signed [15:0] right_distance_mm_i,
  input  logic [7:0]         ack_command_i,
  input  logic [7:0]         ack_sequence_i,
  input  logic [7:0]         ack_status_i,
  output int                 fail_count_o,
  output int                 replies_waiting_o
);

  localparam int PrintCap = 40;

  pos_t       frame_pos;
  logic [7:0] frame_bytes [FrameLength];
  reply_t     replies_due [$];
  int         mismatches = 0;
  int         waiting = 0;

  assign fail_count_o      = mismatches;
  assign replies_waiting_o = waiting;

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    if (mismatches <= PrintCap) begin
      $display("%0t: mismatch on %s: got 0x%h, want 0x%h", $realtime, what, got, want);
    end
  endtask

  // Advances the deframer by one byte; returns 1 when a good frame completes.
  function automatic bit deframe_byte(input logic [7:0] b, output reply_t rep);
    pos_t       p;
    logic [7:0] sum;
    int         i;
    rep = '0;
    p = (frame_pos >= FrameLength) ? PosHeadFirst : frame_pos;
    if (p == PosHeadFirst && b != HeadFirst) begin
      frame_pos = PosHeadFirst;
      return 1'b0;
    end
    if (p == PosHeadSecond && b != HeadSecond) begin
      // A repeated head byte restarts the frame one byte later.
      frame_bytes[0] = b;
      frame_pos = (b == HeadFirst) ? PosHeadSecond : PosHeadFirst;
      return 1'b0;
    end
    frame_bytes[p] = b;
    if (p != PosTail) begin
      frame_pos = pos_t'(p + 1);
      return 1'b0;
    end
    frame_pos = PosHeadFirst;
    sum = '0;
    for (i = 0; i < FrameLength - 2; i++) sum ^= frame_bytes[i];
    if (frame_bytes[PosTail] != FrameTail || frame_bytes[PosCheck] != sum) return 1'b0;
    if (frame_bytes[2] == EncoderCmd) begin
      rep.kind     = ReplyEncoder;
      rep.left_mm  = {frame_bytes[5], frame_bytes[4]};
      rep.right_mm = {frame_bytes[7], frame_bytes[6]};
    end else begin
      rep.kind        = ReplyAck;
      rep.command     = frame_bytes[2];
      rep.sequence_nr = frame_bytes[3];
      rep.status      = frame_bytes[4];
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    reply_t rep;
    reply_t want;
    if (!rst_ni) begin
      frame_pos = PosHeadFirst;
      replies_due.delete();
      waiting = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        if (deframe_byte(rx_byte_i, rep)) replies_due.push_back(rep);
      end
      if (out_valid_i && !out_stall_i) begin
        if (replies_due.size() == 0) begin
          report_mismatch("reply with none expected", {15'd0, reply_kind_i}, 16'd0);
        end else begin
          want = replies_due.pop_front();
          if (reply_kind_i !== want.kind)
            report_mismatch("reply_kind", {15'd0, reply_kind_i}, {15'd0, want.kind});
          if (left_distance_mm_i !== want.left_mm)
            report_mismatch("left_distance_mm", left_distance_mm_i, want.left_mm);
          if (right_distance_mm_i !== want.right_mm)
            report_mismatch("right_distance_mm", right_distance_mm_i, want.right_mm);
          if (ack_command_i !== want.command)
            report_mismatch("ack_command", {8'd0, ack_command_i}, {8'd0, want.command});
          if (ack_sequence_i !== want.sequence_nr)
            report_mismatch("ack_sequence", {8'd0, ack_sequence_i}, {8'd0, want.sequence_nr});
          if (ack_status_i !== want.status)
            report_mismatch("ack_status", {8'd0, ack_status_i}, {8'd0, want.status});
        end
      end
      waiting = replies_due.size();
    end
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import srfp_pkg::*;

  localparam int  ResetCycles  = 10;
  localparam int  PhaseItems   = 425;
  localparam int  HoldCycles   = 300;
  localparam int  DrainCycles  = 12;
  localparam int  CycleLimit   = 400000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         rx_byte = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               reply_kind;
  logic signed [15:0] left_distance_mm;
  logic signed [15:0] right_distance_mm;
  logic [7:0]         ack_command;
  logic [7:0]         ack_sequence;
  logic [7:0]         ack_status;
  int                 fails;
  int                 replies_waiting;

  int                 send_idle_pct = 0;
  int                 recv_stall_pct = 0;
  int                 holds_requested = 0;
  int                 holds_served = 0;
  int                 hold_left = 0;
  int                 cycle_count = 0;
  int                 items_sent = 0;
  logic [7:0]         frame_buf [FrameLength];

  always #6 clk_i = ~clk_i;

  serial_reply_frame_parser dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .rx_byte_i          (rx_byte),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .reply_kind_o       (reply_kind),
    .left_distance_mm_o (left_distance_mm),
    .right_distance_mm_o(right_distance_mm),
    .ack_command_o      (ack_command),
    .ack_sequence_o     (ack_sequence),
    .ack_status_o       (ack_status)
  );

  reply_checker chk (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .rx_byte_i          (rx_byte),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .reply_kind_i       (reply_kind),
    .left_distance_mm_i (left_distance_mm),
    .right_distance_mm_i(right_distance_mm),
    .ack_command_i      (ack_command),
    .ack_sequence_i     (ack_sequence),
    .ack_status_i       (ack_status),
    .fail_count_o       (fails),
    .replies_waiting_o  (replies_waiting)
  );

  // A long hold-off is requested by the stimulus and counted down here.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_requested) begin
      holds_served <= holds_served + 1;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      rx_byte <= 8'($urandom);
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_frame(input int count);
    int i;
    for (i = 0; i < count; i++) send_byte(frame_buf[i]);
    items_sent += count;
  endtask

  function automatic void seal_frame();
    logic [7:0] sum;
    int         i;
    sum = '0;
    for (i = 0; i < FrameLength - 2; i++) sum ^= frame_buf[i];
    frame_buf[PosCheck] = sum;
    frame_buf[PosTail] = FrameTail;
  endfunction

  function automatic void make_frame();
    int i;
    frame_buf[0] = HeadFirst;
    frame_buf[1] = HeadSecond;
    case ($urandom_range(9))
      0, 1, 2, 3: frame_buf[2] = EncoderCmd;
      4:          frame_buf[2] = EncoderCode;
      5:          frame_buf[2] = ReplyBit;
      6:          frame_buf[2] = 8'h00;
      7:          frame_buf[2] = 8'hFF;
      default:    frame_buf[2] = 8'($urandom);
    endcase
    for (i = 3; i < FrameLength - 2; i++) frame_buf[i] = 8'($urandom);
    seal_frame();
  endfunction

  task automatic send_random_sequence();
    int pick;
    int n;
    pick = $urandom_range(99);
    make_frame();
    if (pick < 55) begin
      send_frame(FrameLength);
    end else if (pick < 65) begin
      frame_buf[PosCheck] ^= 8'($urandom_range(1, 255));
      send_frame(FrameLength);
    end else if (pick < 73) begin
      frame_buf[PosTail] ^= 8'($urandom_range(1, 255));
      send_frame(FrameLength);
    end else if (pick < 83) begin
      // Extra head bytes ahead of a good frame exercise the resync path.
      n = $urandom_range(1, 2);
      repeat (n) send_byte(HeadFirst);
      items_sent += n;
      send_frame(FrameLength);
    end else if (pick < 90) begin
      send_frame($urandom_range(2, FrameLength - 1));
    end else if (pick < 95) begin
      send_byte(HeadFirst);
      pick = $urandom_range(255);
      if (pick == HeadSecond || pick == HeadFirst) pick = 8'h00;
      send_byte(8'(pick));
      items_sent += 2;
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) send_byte(8'($urandom));
      items_sent += n;
    end
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    wait (replies_waiting == 0);
    @(negedge clk_i);
  endtask

  initial begin
    int  phase;
    int  phase_start;
    bit  hold_done;
    bit  pause_done;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Bytes while hunting, a resync on a doubled head, then an acknowledge
    // with extreme fields and an encoder report with extreme distances.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(HeadFirst);
    frame_buf = '{HeadFirst, HeadSecond, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h80, 8'h7F,
                  8'h00, 8'h00};
    seal_frame();
    send_frame(FrameLength);
    frame_buf = '{HeadFirst, HeadSecond, EncoderCmd, 8'h55, 8'h00, 8'h80, 8'hFF, 8'h7F,
                  8'h00, 8'h00};
    seal_frame();
    send_frame(FrameLength);
    pause_until_drained();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      phase_start = items_sent;
      hold_done = 1'b0;
      pause_done = 1'b0;
      while (items_sent - phase_start < PhaseItems) begin
        if (!hold_done && items_sent - phase_start > 60) begin
          holds_requested++;
          hold_done = 1'b1;
        end
        if (!pause_done && items_sent - phase_start > 250) begin
          pause_until_drained();
          pause_done = 1'b1;
        end
        send_random_sequence();
      end
      pause_until_drained();
    end

    in_valid <= 1'b0;
    wait (replies_waiting == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: serial_reply_frame_parser.f
rtl/core/srfp_pkg.sv
rtl/core/srfp_in_stage.sv
rtl/core/srfp_frame_track.sv
rtl/core/srfp_out_stage.sv
rtl/core/serial_reply_frame_parser.sv
dv/reply_checker.sv
dv/tb.sv
